// File: rtl/doolittle_lu_decomposition_top_defines.svh
// assertion macros for the checker in lud_check.sv
`ifndef DOOLITTLE_LU_DECOMPOSITION_TOP_DEFINES_SVH
`define DOOLITTLE_LU_DECOMPOSITION_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LUD_CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LUD_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lud_pkg.sv
// ----------------------------------------------------------------------------
// lud_pkg
// Types, constants and the Q16.16 clamp shared by the LU factorization block.
// ----------------------------------------------------------------------------
`default_nettype none

package lud_pkg;

  localparam int IDX_W = 3;
  localparam int DW    = 32;
  localparam int ACC_W = 36;
  localparam int NE    = 2 ** IDX_W;

  localparam logic [DW-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [DW-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [3:0]    SIZE_RST = 4'd8;

  // token moving down the cell chain
  typedef struct packed {
    logic                    vld;
    logic                    rdo;   // readout token, no arithmetic
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [ACC_W-1:0] acc;
    logic                    sat;
    logic [DW-1:0]           lv;
    logic [DW-1:0]           uv;
  } tok_t;

  // write-back into the cell stores
  typedef struct packed {
    logic             vld;
    logic             is_l;
    logic [IDX_W-1:0] sel;
    logic [IDX_W-1:0] idx;
    logic [DW-1:0]    data;
  } wb_t;

  typedef struct packed {
    logic          done;
    logic          sat;
    logic          zpiv;
    logic [DW-1:0] q;
  } div_res_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_UISS,
    ST_UWAIT,
    ST_LISS,
    ST_LWAIT,
    ST_LDIV,
    ST_OISS,
    ST_ODRAIN
  } st_t;

  // saturate a 48-bit signed value to 32 bits, msb of result is the sat flag
  function automatic logic [DW:0] sat_clamp(input logic signed [47:0] v);
    logic [DW:0] res;
    if (v > $signed(48'h0000_7FFF_FFFF)) begin
      res = {1'b1, Q_MAX};
    end else if (v < $signed(48'hFFFF_8000_0000)) begin
      res = {1'b1, Q_MIN};
    end else begin
      res = {1'b0, v[DW-1:0]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/lud_cell.sv
// ----------------------------------------------------------------------------
// lud_cell
// One chain cell: holds column J of L and row J of U, subtracts its rounded
// product from the passing accumulator and serves readout tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module lud_cell #(
  parameter int J = 0
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire lud_pkg::tok_t tok_i,
  input  wire lud_pkg::wb_t  wb,
  output lud_pkg::tok_t      tok_o
);
  import lud_pkg::*;

  localparam logic [IDX_W-1:0] JID = IDX_W'(J);

  logic [DW-1:0] lcol_r [NE];
  logic [DW-1:0] urow_r [NE];

  tok_t               tka_r, tka_nxt;
  tok_t               tkb_r, tkb_nxt;
  logic signed [63:0] prod_r, prod_nxt;

  logic [DW-1:0]      l_rd, u_rd;
  logic signed [63:0] rnd;
  logic [DW:0]        cl;
  logic [IDX_W-1:0]   mn;

  always_ff @(posedge clk) begin
    if (wb.vld && wb.sel == JID) begin
      if (wb.is_l) begin
        lcol_r[wb.idx] <= wb.data;
      end else begin
        urow_r[wb.idx] <= wb.data;
      end
    end
  end

  always_comb begin
    l_rd     = lcol_r[tok_i.row];
    u_rd     = urow_r[tok_i.col];
    prod_nxt = $signed(l_rd) * $signed(u_rd);
    tka_nxt  = tok_i;
    if (tok_i.rdo && tok_i.col == JID) begin
      tka_nxt.lv = l_rd;
    end
    if (tok_i.rdo && tok_i.row == JID) begin
      tka_nxt.uv = u_rd;
    end
  end

  always_comb begin
    rnd     = (prod_r + 64'sd32768) >>> 16;
    cl      = sat_clamp(rnd[47:0]);
    mn      = (tka_r.row < tka_r.col) ? tka_r.row : tka_r.col;
    tkb_nxt = tka_r;
    // only columns left of the current step take part
    if (!tka_r.rdo && JID < mn) begin
      tkb_nxt.acc = tka_r.acc - {{(ACC_W-DW){cl[DW-1]}}, cl[DW-1:0]};
      tkb_nxt.sat = tka_r.sat | cl[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tka_r <= '0;
      tkb_r <= '0;
    end else if (en) begin
      tka_r <= tka_nxt;
      tkb_r <= tkb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign tok_o = tkb_r;

endmodule

`default_nettype wire

// File: rtl/lud_div.sv
// ----------------------------------------------------------------------------
// lud_div
// Q16.16 quotient (num * 2^16) / den, restoring, one bit per cycle,
// truncated toward zero and saturated; a zero divisor is flagged without iterating.
// ----------------------------------------------------------------------------
`default_nettype none

module lud_div (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [lud_pkg::DW-1:0] num,
  input  wire logic [lud_pkg::DW-1:0] den,
  output lud_pkg::div_res_t           res
);
  import lud_pkg::*;

  localparam int QW = DW + 16;
  localparam int CW = $clog2(QW);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [QW-1:0] dvd_r, dvd_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic          neg_r, neg_nxt;
  div_res_t      res_r, res_nxt;

  logic [DW:0]   rsh;
  logic [DW:0]   rdif;
  logic          qb;
  logic [QW-1:0] mag;
  logic [DW-1:0] nmag, dmag;

  always_comb begin
    nmag = num[DW-1] ? (~num + 1'b1) : num;
    dmag = den[DW-1] ? (~den + 1'b1) : den;
    rsh  = {rem_r, dvd_r[QW-1]};
    rdif = rsh - {1'b0, d_r};
    qb   = !rdif[DW];
    mag  = {dvd_r[QW-2:0], qb};
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    res_nxt  = res_r;
    res_nxt.done = 1'b0;
    if (start) begin
      if (den == '0) begin
        res_nxt.done = 1'b1;
        res_nxt.zpiv = 1'b1;
        res_nxt.sat  = (num != '0);
        res_nxt.q    = (num == '0) ? '0 : (num[DW-1] ? Q_MIN : Q_MAX);
      end else begin
        busy_nxt = 1'b1;
        cnt_nxt  = '0;
        dvd_nxt  = {nmag, 16'h0000};
        rem_nxt  = '0;
        d_nxt    = dmag;
        neg_nxt  = num[DW-1] ^ den[DW-1];
      end
    end else if (busy_r) begin
      rem_nxt = qb ? rdif[DW-1:0] : rsh[DW-1:0];
      dvd_nxt = mag;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(QW - 1)) begin
        busy_nxt     = 1'b0;
        res_nxt.done = 1'b1;
        res_nxt.zpiv = 1'b0;
        if (neg_r) begin
          if (mag > QW'({1'b1, {(DW-1){1'b0}}})) begin
            res_nxt.sat = 1'b1;
            res_nxt.q   = Q_MIN;
          end else begin
            res_nxt.sat = 1'b0;
            res_nxt.q   = ~mag[DW-1:0] + 1'b1;
          end
        end else begin
          if (mag > QW'(Q_MAX)) begin
            res_nxt.sat = 1'b1;
            res_nxt.q   = Q_MAX;
          end else begin
            res_nxt.sat = 1'b0;
            res_nxt.q   = mag[DW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      res_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      res_r  <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  assign res = res_r;

endmodule

`default_nettype wire

// File: rtl/doolittle_lu_decomposition_top.sv
// ----------------------------------------------------------------------------
// doolittle_lu_decomposition_top
// Doolittle LU factorization of an n by n signed Q16.16 matrix on a chain
// of MAX_N cells, one L column and one U row per cell.
// ----------------------------------------------------------------------------
// The matrix is loaded one beat per cycle in row-major order; after the last
// beat the block stalls its input, factors, then streams n*n result beats in
// row-major order and only takes a new matrix once the last result is gone.
// Every L or U entry is an accumulator that walks the chain, through two
// registers per cell. A row of U is issued back to back; each L entry makes
// its own pass and then goes through the bit-serial divider before the next
// entry is issued. The size register also restarts the load; write it only
// while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module doolittle_lu_decomposition_top #(
  parameter int MAX_N = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_write_en,
  input  wire logic [3:0]                cfg_matrix_size,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [lud_pkg::DW-1:0] in_matrix_element,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [lud_pkg::IDX_W-1:0]      out_row_index,
  output logic [lud_pkg::IDX_W-1:0]      out_col_index,
  output logic signed [lud_pkg::DW-1:0]  out_l_value,
  output logic signed [lud_pkg::DW-1:0]  out_u_value,
  output logic                           out_zero_pivot,
  output logic                           out_saturated,
  output logic                           out_last_entry
);
  import lud_pkg::*;

  localparam int AW = (MAX_N > 1) ? $clog2(MAX_N * MAX_N) : 1;
  localparam int FW = $clog2(2 * MAX_N + 4) + 1;

  st_t st_r, st_nxt;

  logic [3:0]       size_r;
  logic [3:0]       nsz;
  logic [IDX_W-1:0] nm1;
  logic [IDX_W-1:0] k_r, k_nxt, m_r, m_nxt;
  logic [IDX_W-1:0] lr_r, lr_nxt, lc_r, lc_nxt;
  logic [FW-1:0]    cnt_r, cnt_nxt;
  logic [DW-1:0]    piv_r;
  logic             pf_r, sf_r;

  logic             en;
  logic             acc_in;
  logic             iss;
  logic             fac_start;
  tok_t             iss_tok;
  tok_t             feed_r;
  tok_t             head;
  tok_t             chain [MAX_N+1];
  tok_t             ex;
  logic             ex_fire, u_wr, l_go;
  logic [DW:0]      ex_cl;
  wb_t              wb;
  div_res_t         dres;

  logic [DW-1:0]    amem [MAX_N*MAX_N];
  logic [DW-1:0]    a_rd_r;
  logic [AW-1:0]    wa, ra;

  logic                  ov_r;
  logic [IDX_W-1:0]      orow_r, ocol_r;
  logic [DW-1:0]         ol_r, ou_r;
  logic                  olast_r;

  always_comb begin
    if (size_r == 4'd0) begin
      nsz = 4'd1;
    end else if (size_r > 4'(MAX_N)) begin
      nsz = 4'(MAX_N);
    end else begin
      nsz = size_r;
    end
    nm1 = IDX_W'(nsz - 4'd1);
  end

  assign en     = !ov_r || !out_stall;
  assign acc_in = in_valid && !in_stall;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_LOAD: begin
        if (acc_in && lc_r == nm1 && lr_r == nm1) begin
          st_nxt = ST_UISS;
        end
      end
      ST_UISS: begin
        if (en && m_r == nm1) begin
          st_nxt = ST_UWAIT;
        end
      end
      ST_UWAIT: begin
        if (cnt_r == '0) begin
          st_nxt = (k_r == nm1) ? ST_OISS : ST_LISS;
        end
      end
      ST_LISS: begin
        if (en) begin
          st_nxt = ST_LWAIT;
        end
      end
      ST_LWAIT: begin
        if (l_go) begin
          st_nxt = ST_LDIV;
        end
      end
      ST_LDIV: begin
        if (dres.done) begin
          st_nxt = (m_r == nm1) ? ST_UISS : ST_LISS;
        end
      end
      ST_OISS: begin
        if (en && m_r == nm1 && k_r == nm1) begin
          st_nxt = ST_ODRAIN;
        end
      end
      ST_ODRAIN: begin
        if (cnt_r == '0 && !ov_r) begin
          st_nxt = ST_LOAD;
        end
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  // outputs and counters
  always_comb begin
    in_stall  = 1'b1;
    iss       = 1'b0;
    iss_tok   = '0;
    fac_start = 1'b0;
    k_nxt     = k_r;
    m_nxt     = m_r;
    lr_nxt    = lr_r;
    lc_nxt    = lc_r;
    case (st_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (acc_in) begin
          if (lc_r == nm1) begin
            lc_nxt = '0;
            if (lr_r == nm1) begin
              lr_nxt    = '0;
              fac_start = 1'b1;
              k_nxt     = '0;
              m_nxt     = '0;
            end else begin
              lr_nxt = lr_r + 1'b1;
            end
          end else begin
            lc_nxt = lc_r + 1'b1;
          end
        end
      end
      ST_UISS: begin
        if (en) begin
          iss         = 1'b1;
          iss_tok.vld = 1'b1;
          iss_tok.row = k_r;
          iss_tok.col = m_r;
          if (m_r != nm1) begin
            m_nxt = m_r + 1'b1;
          end
        end
      end
      ST_UWAIT: begin
        if (cnt_r == '0) begin
          if (k_r == nm1) begin
            k_nxt = '0;
            m_nxt = '0;
          end else begin
            m_nxt = k_r + 1'b1;
          end
        end
      end
      ST_LISS: begin
        if (en) begin
          iss         = 1'b1;
          iss_tok.vld = 1'b1;
          iss_tok.row = m_r;
          iss_tok.col = k_r;
        end
      end
      ST_LWAIT: begin
      end
      ST_LDIV: begin
        if (dres.done) begin
          if (m_r == nm1) begin
            k_nxt = k_r + 1'b1;
            m_nxt = k_r + 1'b1;
          end else begin
            m_nxt = m_r + 1'b1;
          end
        end
      end
      ST_OISS: begin
        if (en) begin
          iss         = 1'b1;
          iss_tok.vld = 1'b1;
          iss_tok.rdo = 1'b1;
          iss_tok.row = k_r;
          iss_tok.col = m_r;
          if (m_r == nm1) begin
            m_nxt = '0;
            if (k_r != nm1) begin
              k_nxt = k_r + 1'b1;
            end
          end else begin
            m_nxt = m_r + 1'b1;
          end
        end
      end
      ST_ODRAIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_LOAD;
      size_r <= SIZE_RST;
      k_r    <= '0;
      m_r    <= '0;
      lr_r   <= '0;
      lc_r   <= '0;
      cnt_r  <= '0;
    end else begin
      st_r <= st_nxt;
      k_r  <= k_nxt;
      m_r  <= m_nxt;
      if (cfg_write_en) begin
        size_r <= cfg_matrix_size;
        lr_r   <= '0;
        lc_r   <= '0;
      end else begin
        lr_r <= lr_nxt;
        lc_r <= lc_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // tokens in flight between issue and chain exit
  always_comb begin
    case ({iss, ex_fire})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // matrix store
  assign wa = AW'(int'(lr_r) * MAX_N + int'(lc_r));
  assign ra = AW'(int'(iss_tok.row) * MAX_N + int'(iss_tok.col));

  always_ff @(posedge clk) begin
    if (acc_in) begin
      amem[wa] <= in_matrix_element;
    end
    if (en) begin
      a_rd_r <= amem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feed_r <= '0;
    end else if (en) begin
      feed_r <= iss_tok;
    end
  end

  // accumulator starts from the matrix element
  always_comb begin
    head     = feed_r;
    head.acc = {{(ACC_W-DW){a_rd_r[DW-1]}}, a_rd_r};
  end

  assign chain[0] = head;

  for (genvar g = 0; g < MAX_N; g++) begin : g_cell
    lud_cell #(
      .J(g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .tok_i (chain[g]),
      .wb    (wb),
      .tok_o (chain[g+1])
    );
  end

  assign ex      = chain[MAX_N];
  assign ex_fire = en && ex.vld;
  assign ex_cl   = sat_clamp({{(48-ACC_W){ex.acc[ACC_W-1]}}, ex.acc});
  assign u_wr    = ex_fire && !ex.rdo && (ex.row <= ex.col);
  assign l_go    = ex_fire && !ex.rdo && (ex.row > ex.col);

  lud_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (l_go),
    .num   (ex_cl[DW-1:0]),
    .den   (piv_r),
    .res   (dres)
  );

  always_comb begin
    wb = '0;
    if (u_wr) begin
      wb.vld  = 1'b1;
      wb.is_l = 1'b0;
      wb.sel  = ex.row;
      wb.idx  = ex.col;
      wb.data = ex_cl[DW-1:0];
    end else if (dres.done) begin
      wb.vld  = 1'b1;
      wb.is_l = 1'b1;
      wb.sel  = k_r;
      wb.idx  = m_r;
      wb.data = dres.q;
    end
  end

  always_ff @(posedge clk) begin
    if (u_wr && ex.row == ex.col) begin
      piv_r <= ex_cl[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pf_r <= 1'b0;
      sf_r <= 1'b0;
    end else if (fac_start) begin
      pf_r <= 1'b0;
      sf_r <= 1'b0;
    end else begin
      if (u_wr || l_go) begin
        sf_r <= sf_r | ex.sat | ex_cl[DW];
      end
      if (u_wr && ex.row == ex.col && ex_cl[DW-1:0] == '0) begin
        pf_r <= 1'b1;
      end
      if (dres.done) begin
        sf_r <= sf_r | dres.sat;
        pf_r <= pf_r | dres.zpiv;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= ex.vld && ex.rdo;
    end
  end

  always_ff @(posedge clk) begin
    if (en && ex.vld && ex.rdo) begin
      orow_r  <= ex.row;
      ocol_r  <= ex.col;
      ol_r    <= (ex.row > ex.col) ? ex.lv : ((ex.row == ex.col) ? Q_ONE : '0);
      ou_r    <= (ex.row <= ex.col) ? ex.uv : '0;
      olast_r <= (ex.row == nm1) && (ex.col == nm1);
    end
  end

  assign out_valid      = ov_r;
  assign out_row_index  = orow_r;
  assign out_col_index  = ocol_r;
  assign out_l_value    = ol_r;
  assign out_u_value    = ou_r;
  assign out_zero_pivot = pf_r;
  assign out_saturated  = sf_r;
  assign out_last_entry = olast_r;

endmodule

`default_nettype wire

// File: rtl/lud_check.sv
// ----------------------------------------------------------------------------
// lud_check
// Port-level checks for the LU factorization block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "doolittle_lu_decomposition_top_defines.svh"

module lud_check (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [lud_pkg::IDX_W-1:0] out_row_index,
  input wire logic [lud_pkg::IDX_W-1:0] out_col_index,
  input wire logic [lud_pkg::DW-1:0]    out_l_value,
  input wire logic [lud_pkg::DW-1:0]    out_u_value,
  input wire logic                      out_last_entry
);
  import lud_pkg::*;

  `LUD_CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid,
                "result beat dropped while stalled")
  `LUD_CHK_NEXT(a_out_stable, out_valid && out_stall,
                $stable(out_l_value) && $stable(out_u_value), "stalled result changed")
  `LUD_CHK_SAME(a_no_load_in_out, out_valid, in_stall, "input taken while results pending")
  `LUD_CHK_SAME(a_last_diag, out_valid && out_last_entry,
                out_row_index == out_col_index, "last beat off the diagonal")
  `LUD_CHK_SAME(a_l_diag_one, out_valid && out_row_index == out_col_index,
                out_l_value == Q_ONE, "L diagonal not one")

endmodule

bind doolittle_lu_decomposition_top lud_check u_lud_check (.*);

`default_nettype wire
